@@ rtl/core/cbd_pkg.sv @@
// Shared types and constants for the chunked body decoder.
`timescale 1ns / 1ps

package cbd_pkg;

  // Width of the chunk size and of the reported length
  localparam int SIZE_W = 32;
  localparam int LEN_W  = 32;

  // Largest size that may still take another hex digit
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = 32'h0FFF_FFFF;

  // Line syntax characters
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // Parser phase
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_SIZE_CR = 3'd2,
    PH_DATA    = 3'd3,
    PH_TAIL    = 3'd4,
    PH_TAIL_LF = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_COMPLETE   = 2'd1,
    KIND_MALFORMED  = 2'd2,
    KIND_INCOMPLETE = 2'd3
  } kind_t;

  // One result item
  typedef struct packed {
    logic [7:0]       data;
    kind_t            kind;
    logic [LEN_W-1:0] len;
    logic             last;
  } res_t;

endpackage

@@ rtl/core/cbd_step.sv @@
// Per-byte parser step: next state and up to two results for one byte.
`timescale 1ns / 1ps

module cbd_step
  import cbd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  phase_t                  phase,
  input  logic [SIZE_W-1:0]       remain,
  input  logic                    digit_seen,
  input  logic [COUNT_BITS-1:0]   count,
  input  logic [7:0]              byte_in,
  input  logic                    eob,
  output phase_t                  phase_nxt,
  output logic [SIZE_W-1:0]       remain_nxt,
  output logic                    digit_seen_nxt,
  output logic [COUNT_BITS-1:0]   count_nxt,
  output logic                    res0_vld,
  output logic                    res1_vld,
  output res_t                    res0,
  output res_t                    res1
);

  phase_t                ph;
  logic [SIZE_W-1:0]     rem;
  logic                  dig;
  logic [COUNT_BITS-1:0] cnt;
  logic                  pay_vld;
  logic                  stat_vld;
  kind_t                 stat_kind;
  logic                  line_end;
  logic                  hex_ok;
  logic [3:0]            hex_val;
  logic [SIZE_W-1:0]     rem_dec;
  logic [LEN_W-1:0]      len;
  res_t                  pay_res;
  res_t                  stat_res;

  // Decode one hex digit
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (byte_in >= "0" && byte_in <= "9") begin
      hex_val = 4'(byte_in - 8'h30);
    end else if (byte_in >= "a" && byte_in <= "f") begin
      hex_val = 4'(byte_in - 8'h57);
    end else if (byte_in >= "A" && byte_in <= "F") begin
      hex_val = 4'(byte_in - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign rem_dec = (remain != '0) ? remain - 1'b1 : remain;

  // Phase update and status detection
  always_comb begin
    ph        = phase;
    rem       = remain;
    dig       = digit_seen;
    cnt       = count;
    pay_vld   = 1'b0;
    stat_vld  = 1'b0;
    stat_kind = KIND_MALFORMED;
    line_end  = 1'b0;

    unique case (phase)
      PH_SIZE: begin
        if (byte_in == CH_SEMI) begin
          ph = PH_EXT;
        end else if (byte_in == CH_CR) begin
          ph = PH_SIZE_CR;
        end else if (byte_in == CH_LF) begin
          line_end = 1'b1;
        end else if (!hex_ok || remain > SIZE_LIMIT) begin
          stat_vld = 1'b1;
        end else begin
          rem = {remain[SIZE_W-5:0], hex_val};
          dig = 1'b1;
        end
      end
      PH_EXT: begin
        line_end = (byte_in == CH_LF);
      end
      PH_SIZE_CR: begin
        if (byte_in == CH_LF) begin
          line_end = 1'b1;
        end else begin
          stat_vld = 1'b1;
        end
      end
      PH_DATA: begin
        pay_vld = 1'b1;
        if (count != '1) begin
          cnt = count + 1'b1;
        end
        rem = rem_dec;
        if (rem_dec == '0) begin
          ph = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (byte_in == CH_CR) begin
          ph = PH_TAIL_LF;
        end else if (byte_in == CH_LF) begin
          ph = PH_SIZE;
        end else begin
          stat_vld = 1'b1;
        end
      end
      PH_TAIL_LF: begin
        if (byte_in == CH_LF) begin
          ph = PH_SIZE;
        end else begin
          stat_vld = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    // Close the size line: no digits, zero size or start of payload
    if (line_end) begin
      dig = 1'b0;
      if (!digit_seen) begin
        stat_vld = 1'b1;
      end else if (remain == '0) begin
        stat_vld  = 1'b1;
        stat_kind = KIND_COMPLETE;
      end else begin
        ph = PH_DATA;
      end
    end

    if (stat_vld) begin
      ph = PH_DONE;
    end

    // Buffer end: flag a missing status, then start over
    if (eob && ph != PH_DONE) begin
      stat_vld  = 1'b1;
      stat_kind = KIND_INCOMPLETE;
    end
  end

  // Fit the counter to the reported length width: saturate if wider, zero-extend if narrower
  if (COUNT_BITS > LEN_W) begin : g_len_wide
    assign len = (|cnt[COUNT_BITS-1:LEN_W]) ? '1 : cnt[LEN_W-1:0];
  end else if (COUNT_BITS == LEN_W) begin : g_len_eq
    assign len = cnt;
  end else begin : g_len_narrow
    assign len = {{(LEN_W-COUNT_BITS){1'b0}}, cnt};
  end

  // Next state, cleared at buffer end
  always_comb begin
    if (eob) begin
      phase_nxt      = PH_SIZE;
      remain_nxt     = '0;
      digit_seen_nxt = 1'b0;
      count_nxt      = '0;
    end else begin
      phase_nxt      = ph;
      remain_nxt     = rem;
      digit_seen_nxt = dig;
      count_nxt      = cnt;
    end
  end

  // Order results: payload byte first, status after it
  always_comb begin
    pay_res.data  = byte_in;
    pay_res.kind  = KIND_PAYLOAD;
    pay_res.len   = len;
    pay_res.last  = !stat_vld;
    stat_res.data = 8'd0;
    stat_res.kind = stat_kind;
    stat_res.len  = len;
    stat_res.last = 1'b1;
    res0_vld      = pay_vld || stat_vld;
    res1_vld      = pay_vld && stat_vld;
    res0          = pay_vld ? pay_res : stat_res;
    res1          = stat_res;
  end

endmodule

@@ rtl/core/cbd_outq.sv @@
// Two-slot result buffer: output register plus one pending result.
`timescale 1ns / 1ps

module cbd_outq
  import cbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic res0_vld,
  input  logic res1_vld,
  input  res_t res0,
  input  res_t res1,
  output logic can_take,
  input  logic out_stall,
  output logic out_valid,
  output res_t out_res
);

  logic a_vld_r;
  logic b_vld_r;
  res_t a_r;
  res_t b_r;
  logic pop;

  assign pop       = a_vld_r && !out_stall;
  assign can_take  = !b_vld_r && (!a_vld_r || pop);
  assign out_valid = a_vld_r;
  assign out_res   = a_r;

  // Slot occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (b_vld_r && pop) begin
      b_vld_r <= 1'b0;
    end else if (push && res0_vld) begin
      a_vld_r <= 1'b1;
      b_vld_r <= res1_vld;
    end else if (pop) begin
      a_vld_r <= 1'b0;
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (b_vld_r && pop) begin
      a_r <= b_r;
    end else if (push && res0_vld) begin
      a_r <= res0;
      b_r <= res1;
    end
  end

  // Pending slot is only used behind a full output slot
  assert property (@(posedge clk) disable iff (!rst_n) b_vld_r |-> a_vld_r)
    else $error("pending result without output result");

  // A transfer that is not the last of its byte is followed by the rest
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !out_stall && !a_r.last) |=> a_vld_r)
    else $error("second result of a byte went missing");

  // Statuses always close the byte's results
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && a_r.kind != KIND_PAYLOAD) |-> a_r.last)
    else $error("status result not marked last");

endmodule

@@ rtl/core/chunked_body_decoder_top.sv @@
// Top level of the chunked body decoder: input register, parser state, result buffer.
`timescale 1ns / 1ps

// Usage:
//   The input channel (in_valid / in_stall) carries one byte of a chunk-encoded
//   body per transfer; in_end_of_buffer marks the buffer's last byte.
//   The output channel (out_valid / out_stall) carries decoded payload bytes
//   (kind payload) and the buffer's status (complete, malformed, incomplete),
//   with the running decoded length; out_last_of_run closes each byte's results.
//   A transfer is taken at a clock edge with valid high and stall low.
//   A byte passes the input register, then the result buffer's output register,
//   before its first result is offered. Throughput: one byte per cycle while
//   out_stall is low; a byte that yields a payload byte plus an incomplete
//   status holds the input until its status leaves the pending slot.
//   Each buffer end returns the parser to its reset state.
//   Reset (rst_n low, synchronous) empties the input register and result
//   buffer and puts the parser at the start of a size line.
//   When the receiver stalls, the offered result holds and a byte's second
//   result waits in the pending slot; in_stall rises as soon as the input
//   register holds a byte that has no room in the result buffer.

module chunked_body_decoder_top
  import cbd_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             in_end_of_buffer,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic [LEN_W-1:0] out_decoded_length,
  output logic             out_last_of_run
);

  logic                  in_vld_r;
  logic [7:0]            in_byte_r;
  logic                  in_eob_r;
  phase_t                phase_r;
  phase_t                phase_nxt;
  logic [SIZE_W-1:0]     remain_r;
  logic [SIZE_W-1:0]     remain_nxt;
  logic                  digit_r;
  logic                  digit_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;
  logic                  res0_vld;
  logic                  res1_vld;
  res_t                  res0;
  res_t                  res1;
  res_t                  out_res;
  logic                  can_take;
  logic                  adv;
  logic                  in_xfer;

  assign adv      = in_vld_r && can_take;
  assign in_stall = in_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_byte;
      in_eob_r  <= in_end_of_buffer;
    end
  end

  // Parser state, advanced once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIZE;
      remain_r <= '0;
      digit_r  <= 1'b0;
      count_r  <= '0;
    end else if (adv) begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      digit_r  <= digit_nxt;
      count_r  <= count_nxt;
    end
  end

  cbd_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .phase          (phase_r),
    .remain         (remain_r),
    .digit_seen     (digit_r),
    .count          (count_r),
    .byte_in        (in_byte_r),
    .eob            (in_eob_r),
    .phase_nxt      (phase_nxt),
    .remain_nxt     (remain_nxt),
    .digit_seen_nxt (digit_nxt),
    .count_nxt      (count_nxt),
    .res0_vld       (res0_vld),
    .res1_vld       (res1_vld),
    .res0           (res0),
    .res1           (res1)
  );

  cbd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .res0_vld  (res0_vld),
    .res1_vld  (res1_vld),
    .res0      (res0),
    .res1      (res1),
    .can_take  (can_take),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_byte           = out_res.data;
  assign out_kind           = out_res.kind;
  assign out_decoded_length = out_res.len;
  assign out_last_of_run    = out_res.last;

  // Buffer end clears the parser
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_eob_r) |=> (phase_r == PH_SIZE && count_r == '0 && !digit_r))
    else $error("parser not cleared after buffer end");

  // Payload bytes only come from the payload phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res0_vld && res0.kind == KIND_PAYLOAD) |-> (phase_r == PH_DATA))
    else $error("payload result outside payload phase");

  // Payload phase is never entered with nothing left to pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (remain_r != '0))
    else $error("payload phase with empty chunk");

endmodule
